// ===== hw/rtl/tour_crossover_repair_top_macros.svh =====
// ----------------------------------------------------------------------------
// tour_crossover_repair_top_macros.svh
// assertion macros shared by the tour crossover repair rtl
// ----------------------------------------------------------------------------
`ifndef TOUR_CROSSOVER_REPAIR_TOP_MACROS_SVH
`define TOUR_CROSSOVER_REPAIR_TOP_MACROS_SVH

// same-cycle implication
`define TCR_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tcr check failed");

// next-cycle implication
`define TCR_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tcr check failed");

`endif

// ===== hw/rtl/tcr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcr_pkg
// types, constants and helpers for the tour crossover repair block
// ----------------------------------------------------------------------------
package tcr_pkg;

  localparam int MAX_NODES   = 32;
  localparam int STORE_DEPTH = 32;
  localparam int NODE_W      = 5;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = 6;
  localparam int POS_W       = 6;
  localparam int N_HI        = (MAX_NODES < STORE_DEPTH) ? MAX_NODES : STORE_DEPTH;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(32);
  localparam logic [CNT_W-1:0] MIN_NODES      = CNT_W'(4);
  localparam logic [CNT_W-1:0] MAX_EFF        = CNT_W'(N_HI);
  localparam logic [CNT_W-1:0] CUT_MIN        = CNT_W'(2);
  localparam logic [POS_W-1:0] POS_MAX        = POS_W'((2 ** POS_W) - 1);
  localparam logic [1:0]       CNT_SAT        = 2'd3;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [1:0]        occ_t;
  typedef logic [CNT_W-1:0]  ncnt_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_BUILD,
    ST_REPAIR,
    ST_SWAP_RD,
    ST_SWAP_WP,
    ST_SWAP_WQ,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    LOP_NONE,
    LOP_BUILD,
    LOP_REPAIR,
    LOP_SWAP_RD,
    LOP_SWAP_WP,
    LOP_SWAP_WQ
  } lane_op_e;

  typedef struct packed {
    lane_op_e op;
    logic     clr;
    idx_t     idx;
    node_t    build_node;
    ncnt_t    n;
    logic     swap_en;
    idx_t     swap_p;
    idx_t     swap_q;
  } lane_ctrl_t;

  function automatic occ_t sat_inc(input occ_t c);
    occ_t r;
    r = (c == CNT_SAT) ? c : occ_t'(c + 2'd1);
    return r;
  endfunction

  function automatic logic swap_ok(input logic en, input node_t p, input node_t q,
                                   input ncnt_t n);
    logic r;
    r = en && (p != '0) && (ncnt_t'(p) < n) && (q != '0) && (ncnt_t'(q) < n);
    return r;
  endfunction

endpackage

// ===== hw/rtl/tcr_lane.sv =====
// ----------------------------------------------------------------------------
// tcr_lane
// one child lane: child store, occurrence counts, missing-node search, swap
// ----------------------------------------------------------------------------
module tcr_lane (
  input  logic                clk_i,
  input  tcr_pkg::lane_ctrl_t ctrl_i,
  output tcr_pkg::node_t      node_o
);

  tcr_pkg::node_t child_q [tcr_pkg::STORE_DEPTH];
  tcr_pkg::occ_t  cnt_q   [tcr_pkg::STORE_DEPTH];
  tcr_pkg::node_t tmp_q;

  tcr_pkg::idx_t  rd_addr;
  tcr_pkg::node_t rd_node;
  logic           found;
  tcr_pkg::idx_t  free_k;
  logic           dup;
  logic           wr_en;
  tcr_pkg::idx_t  wr_addr;
  tcr_pkg::node_t wr_data;
  logic           bump_en;
  tcr_pkg::idx_t  bump_node;

  always_comb begin
    case (ctrl_i.op)
      tcr_pkg::LOP_SWAP_RD: rd_addr = ctrl_i.swap_p;
      tcr_pkg::LOP_SWAP_WP: rd_addr = ctrl_i.swap_q;
      default:              rd_addr = ctrl_i.idx;
    endcase
    rd_node = child_q[rd_addr];
  end

  // lowest node below n that has not been seen yet
  always_comb begin
    found  = 1'b0;
    free_k = '0;
    for (int k = tcr_pkg::STORE_DEPTH - 1; k >= 0; k--) begin
      if (cnt_q[k] == 2'd0 && tcr_pkg::CNT_W'(k) < ctrl_i.n) begin
        found  = 1'b1;
        free_k = tcr_pkg::IDX_W'(k);
      end
    end
  end

  assign dup = (cnt_q[rd_node] == tcr_pkg::CNT_SAT);

  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = ctrl_i.idx;
    wr_data   = rd_node;
    bump_en   = 1'b0;
    bump_node = rd_node;
    unique case (ctrl_i.op)
      tcr_pkg::LOP_BUILD: begin
        wr_en     = 1'b1;
        wr_data   = ctrl_i.build_node;
        bump_en   = 1'b1;
        bump_node = ctrl_i.build_node;
      end
      tcr_pkg::LOP_REPAIR: begin
        bump_en = 1'b1;
        if (dup && found) begin
          wr_en     = 1'b1;
          wr_data   = free_k;
          bump_node = free_k;
        end
      end
      tcr_pkg::LOP_SWAP_WP: begin
        wr_en   = ctrl_i.swap_en;
        wr_addr = ctrl_i.swap_p;
        wr_data = rd_node;
      end
      tcr_pkg::LOP_SWAP_WQ: begin
        wr_en   = ctrl_i.swap_en;
        wr_addr = ctrl_i.swap_q;
        wr_data = tmp_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      child_q[wr_addr] <= wr_data;
    end
    if (ctrl_i.clr) begin
      for (int k = 0; k < tcr_pkg::STORE_DEPTH; k++) begin
        cnt_q[k] <= '0;
      end
    end else if (bump_en) begin
      cnt_q[bump_node] <= tcr_pkg::sat_inc(cnt_q[bump_node]);
    end
    if (ctrl_i.op == tcr_pkg::LOP_SWAP_RD) begin
      tmp_q <= rd_node;
    end
  end

  assign node_o = rd_node;

endmodule

// ===== hw/rtl/tcr_merge.sv =====
// ----------------------------------------------------------------------------
// tcr_merge
// joins both lanes into one result beat and holds it in the output register
// ----------------------------------------------------------------------------
module tcr_merge (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  tcr_pkg::node_t node_a_i,
  input  tcr_pkg::node_t node_b_i,
  input  tcr_pkg::idx_t  pos_i,
  input  logic           last_i,
  output logic           ready_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tcr_pkg::node_t child_a_node_o,
  output tcr_pkg::node_t child_b_node_o,
  output tcr_pkg::idx_t  out_position_o,
  output logic           out_last_o
);

  logic           valid_q, valid_d;
  tcr_pkg::node_t a_q, b_q;
  tcr_pkg::idx_t  pos_q;
  logic           last_q;

  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = ready_o ? load_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      a_q    <= node_a_i;
      b_q    <= node_b_i;
      pos_q  <= pos_i;
      last_q <= last_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign child_a_node_o = a_q;
  assign child_b_node_o = b_q;
  assign out_position_o = pos_q;
  assign out_last_o     = last_q;

endmodule

// ===== hw/rtl/tour_crossover_repair_top.sv =====
// ----------------------------------------------------------------------------
// tour_crossover_repair_top
// single-point crossover of two tours with duplicate repair and swap
// ----------------------------------------------------------------------------
// input channel: one beat per tour position, carrying a node of each parent;
//   the beat with load_last_i set also carries cut point and swap draws
// output channel: n beats per pair, one per position, out_last_o on the last
// cfg: cfg_we_i writes cfg_node_count_i (n, clamped to 4..32), reset 32
// loading accepts a beat whenever in_stall_o is low; after the last beat in_stall_o
//   stays high through build and count, repair, the swap states SWAP_RD, SWAP_WP
//   and SWAP_WQ, and emission, where the n results go out at one beat per cycle
//   while the receiver does not stall
// build and repair run in the two child lanes, which step through one store
//   entry per cycle; the search for the missing node sits in each lane
// the first result beat reaches the output register once the swap states are done
// a stall on the output holds the beat in the output register and pauses
//   emission; the next pair is taken while the final beat still waits
// reset empties the output register, clears the load position and sets n
// ----------------------------------------------------------------------------
`include "tour_crossover_repair_top_macros.svh"

module tour_crossover_repair_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_node_count_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [4:0] parent_a_node_i,
  input  logic [4:0] parent_b_node_i,
  input  logic [4:0] cut_point_i,
  input  logic       mutate_a_i,
  input  logic [4:0] swap_a_first_i,
  input  logic [4:0] swap_a_second_i,
  input  logic       mutate_b_i,
  input  logic [4:0] swap_b_first_i,
  input  logic [4:0] swap_b_second_i,
  input  logic       load_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [4:0] child_a_node_o,
  output logic [4:0] child_b_node_o,
  output logic [4:0] out_position_o,
  output logic       out_last_o
);

  tcr_pkg::ncnt_t  node_count_q;
  tcr_pkg::state_e state_q, state_d;
  logic [tcr_pkg::POS_W-1:0] pos_q;
  tcr_pkg::idx_t   j_q, j_d;
  tcr_pkg::idx_t   cut_q;
  logic            en_a_q, en_b_q;
  tcr_pkg::idx_t   pa_q, qa_q, pb_q, qb_q;
  tcr_pkg::node_t  parent_a_q [tcr_pkg::STORE_DEPTH];
  tcr_pkg::node_t  parent_b_q [tcr_pkg::STORE_DEPTH];

  tcr_pkg::ncnt_t  n_eff, n_m1, n_m2, cut_c;
  logic            in_acc, pair_done, j_end;
  tcr_pkg::lane_op_e  lop;
  tcr_pkg::lane_ctrl_t ctrl_a, ctrl_b;
  tcr_pkg::node_t  lane_a_node, lane_b_node;
  logic            mg_load, mg_ready;

  always_comb begin
    if (node_count_q < tcr_pkg::MIN_NODES) begin
      n_eff = tcr_pkg::MIN_NODES;
    end else if (node_count_q > tcr_pkg::MAX_EFF) begin
      n_eff = tcr_pkg::MAX_EFF;
    end else begin
      n_eff = node_count_q;
    end
  end

  assign n_m1      = n_eff - tcr_pkg::ncnt_t'(1);
  assign n_m2      = n_eff - tcr_pkg::ncnt_t'(2);
  assign j_end     = (tcr_pkg::ncnt_t'(j_q) == n_m1);
  assign in_stall_o = (state_q != tcr_pkg::ST_LOAD);
  assign in_acc    = in_valid_i && !in_stall_o;
  assign pair_done = in_acc && load_last_i;

  always_comb begin
    if (tcr_pkg::ncnt_t'(cut_point_i) > n_m2) begin
      cut_c = n_m2;
    end else if (tcr_pkg::ncnt_t'(cut_point_i) < tcr_pkg::CUT_MIN) begin
      cut_c = tcr_pkg::CUT_MIN;
    end else begin
      cut_c = tcr_pkg::ncnt_t'(cut_point_i);
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    j_d     = j_q;
    lop     = tcr_pkg::LOP_NONE;
    mg_load = 1'b0;
    unique case (state_q)
      tcr_pkg::ST_LOAD: begin
        if (pair_done) begin
          state_d = tcr_pkg::ST_BUILD;
          j_d     = '0;
        end
      end
      tcr_pkg::ST_BUILD: begin
        lop = tcr_pkg::LOP_BUILD;
        j_d = j_end ? '0 : tcr_pkg::idx_t'(j_q + 1'b1);
        if (j_end) begin
          state_d = tcr_pkg::ST_REPAIR;
        end
      end
      tcr_pkg::ST_REPAIR: begin
        lop = tcr_pkg::LOP_REPAIR;
        j_d = j_end ? '0 : tcr_pkg::idx_t'(j_q + 1'b1);
        if (j_end) begin
          state_d = tcr_pkg::ST_SWAP_RD;
        end
      end
      tcr_pkg::ST_SWAP_RD: begin
        lop     = tcr_pkg::LOP_SWAP_RD;
        state_d = tcr_pkg::ST_SWAP_WP;
      end
      tcr_pkg::ST_SWAP_WP: begin
        lop     = tcr_pkg::LOP_SWAP_WP;
        state_d = tcr_pkg::ST_SWAP_WQ;
      end
      tcr_pkg::ST_SWAP_WQ: begin
        lop     = tcr_pkg::LOP_SWAP_WQ;
        state_d = tcr_pkg::ST_EMIT;
        j_d     = '0;
      end
      tcr_pkg::ST_EMIT: begin
        mg_load = 1'b1;
        if (mg_ready) begin
          j_d = j_end ? '0 : tcr_pkg::idx_t'(j_q + 1'b1);
          if (j_end) begin
            state_d = tcr_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_d = tcr_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tcr_pkg::ST_LOAD;
      j_q          <= '0;
      pos_q        <= '0;
      node_count_q <= tcr_pkg::NODE_COUNT_RST;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      if (cfg_we_i) begin
        node_count_q <= cfg_node_count_i;
      end
      if (in_acc) begin
        if (load_last_i) begin
          pos_q <= '0;
        end else if (pos_q != tcr_pkg::POS_MAX) begin
          pos_q <= pos_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (tcr_pkg::ncnt_t'(pos_q) < n_eff)) begin
      parent_a_q[pos_q[tcr_pkg::IDX_W-1:0]] <= parent_a_node_i;
      parent_b_q[pos_q[tcr_pkg::IDX_W-1:0]] <= parent_b_node_i;
    end
    if (pair_done) begin
      cut_q  <= cut_c[tcr_pkg::IDX_W-1:0];
      en_a_q <= tcr_pkg::swap_ok(mutate_a_i, swap_a_first_i, swap_a_second_i, n_eff);
      pa_q   <= swap_a_first_i;
      qa_q   <= swap_a_second_i;
      en_b_q <= tcr_pkg::swap_ok(mutate_b_i, swap_b_first_i, swap_b_second_i, n_eff);
      pb_q   <= swap_b_first_i;
      qb_q   <= swap_b_second_i;
    end
  end

  always_comb begin
    ctrl_a.op         = lop;
    ctrl_a.clr        = pair_done;
    ctrl_a.idx        = j_q;
    ctrl_a.build_node = (j_q < cut_q) ? parent_a_q[j_q] : parent_b_q[j_q];
    ctrl_a.n          = n_eff;
    ctrl_a.swap_en    = en_a_q;
    ctrl_a.swap_p     = pa_q;
    ctrl_a.swap_q     = qa_q;

    ctrl_b.op         = lop;
    ctrl_b.clr        = pair_done;
    ctrl_b.idx        = j_q;
    ctrl_b.build_node = (j_q < cut_q) ? parent_b_q[j_q] : parent_a_q[j_q];
    ctrl_b.n          = n_eff;
    ctrl_b.swap_en    = en_b_q;
    ctrl_b.swap_p     = pb_q;
    ctrl_b.swap_q     = qb_q;
  end

  tcr_lane u_lane_a (
    .clk_i  (clk_i),
    .ctrl_i (ctrl_a),
    .node_o (lane_a_node)
  );

  tcr_lane u_lane_b (
    .clk_i  (clk_i),
    .ctrl_i (ctrl_b),
    .node_o (lane_b_node)
  );

  tcr_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (mg_load),
    .node_a_i       (lane_a_node),
    .node_b_i       (lane_b_node),
    .pos_i          (j_q),
    .last_i         (j_end),
    .ready_o        (mg_ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .child_a_node_o (child_a_node_o),
    .child_b_node_o (child_b_node_o),
    .out_position_o (out_position_o),
    .out_last_o     (out_last_o)
  );

  `TCR_ASSERT_NXT(a_pair_start, clk_i, rst_ni, pair_done, (state_q == tcr_pkg::ST_BUILD) && (j_q == '0))
  `TCR_ASSERT_NXT(a_emit_end, clk_i, rst_ni, (state_q == tcr_pkg::ST_EMIT) && mg_ready && j_end, (state_q == tcr_pkg::ST_LOAD) && out_valid_o && out_last_o)
  `TCR_ASSERT_NXT(a_beat_order, clk_i, rst_ni, out_valid_o && !out_stall_i && !out_last_o, out_valid_o && (out_position_o == $past(out_position_o) + 1'b1))
  `TCR_ASSERT_IMP(a_emit_stall, clk_i, rst_ni, (state_q == tcr_pkg::ST_EMIT) || (state_q == tcr_pkg::ST_REPAIR), in_stall_o && !pair_done)

endmodule
